>>> hdl/tcpt_pkg.sv
package tcpt_pkg;

  localparam int NUM_TRACKS = 16;
  localparam int MAX_POINTS = 64;
  localparam int NUM_LANES  = NUM_TRACKS + 1;

  localparam int LANE_W = $clog2(NUM_LANES);
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DEPTH  = NUM_LANES * MAX_POINTS;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    K_GLOBAL = 3'd0,
    K_TRACK  = 3'd1,
    K_PLAIN  = 3'd2,
    K_QUERY  = 3'd3,
    K_CLEAR  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic              has_track;
    logic [3:0]        track_id;
    logic [31:0]       tick;
    logic signed [7:0] amount;
  } item_t;

  typedef struct packed {
    logic signed [8:0] total;
    logic              overflow;
  } result_t;

  typedef struct packed {
    logic [31:0] tick;
    logic [7:0]  value;
  } point_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [2:0] kind;
  } ctrl_status_t;

  function automatic logic signed [8:0] sext9(input logic [7:0] v);
    return {v[7], v};
  endfunction

  function automatic logic [ADDR_W-1:0] point_addr(input logic [LANE_W-1:0] lane,
                                                   input logic [IDX_W-1:0] idx);
    return ADDR_W'(lane) * ADDR_W'(MAX_POINTS) + ADDR_W'(idx);
  endfunction

endpackage

>>> hdl/tcpt_ram.sv
module tcpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/tcpt_ctrl.sv
module tcpt_ctrl import tcpt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  item_t             item,
  input  logic              take,
  output result_t           res,
  output ctrl_status_t      status,
  output logic              we,
  output logic [ADDR_W-1:0] waddr,
  output point_t            wdata,
  output logic [ADDR_W-1:0] raddr,
  input  point_t            rdata
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_LAST_CHK = 7'b0000100,
    S_TOTAL    = 7'b0001000,
    S_Q_ISSUE  = 7'b0010000,
    S_Q_CMP    = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t            state;
  item_t             cur;
  logic [LANE_W-1:0] lane;
  logic [LANE_W-1:0] e_lane;
  logic [LANE_W-1:0] q_lane;
  logic              do_evt;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [7:0]        val;
  logic signed [8:0] acc;
  logic [CNT_W-1:0]  count [NUM_LANES];
  logic [7:0]        running [NUM_LANES];

  logic [LANE_W-1:0] item_lane;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  n_evt;
  logic [IDX_W-1:0]  last_idx;
  logic              same_tick;
  logic              same_value;

  always_comb begin
    item_lane = '0;
    if (item.has_track && int'(item.track_id) < NUM_TRACKS) begin
      item_lane = LANE_W'(item.track_id) + LANE_W'(1);
    end
    mid        = lo + ((hi - lo) >> 1);
    n_evt      = count[e_lane];
    last_idx   = IDX_W'(n_evt - CNT_W'(1));
    same_tick  = (rdata.tick == cur.tick);
    same_value = (rdata.value == cur.amount);
  end

  // point memory port: last-entry read on dispatch, bisection reads otherwise
  always_comb begin
    we    = 1'b0;
    waddr = point_addr(e_lane, last_idx);
    wdata = '{tick: cur.tick, value: cur.amount};
    raddr = point_addr(q_lane, mid[IDX_W-1:0]);
    unique case (state)
      S_DISPATCH: begin
        raddr = point_addr(e_lane, last_idx);
        if (cur.kind != K_CLEAR && cur.kind != K_QUERY && do_evt && n_evt == '0) begin
          we    = 1'b1;
          waddr = point_addr(e_lane, '0);
        end
      end
      S_LAST_CHK: begin
        if (same_tick) begin
          we = 1'b1;
        end else if (!same_value && n_evt != CNT_W'(MAX_POINTS)) begin
          we    = 1'b1;
          waddr = point_addr(e_lane, IDX_W'(n_evt));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_LANES; i++) begin
        count[i]   <= '0;
        running[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur    <= item;
            lane   <= item_lane;
            e_lane <= (item.kind == K_GLOBAL) ? '0 : item_lane;
            do_evt <= (item.kind == K_GLOBAL) ||
                      (item.kind == K_TRACK && item_lane != '0);
            state  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res.overflow <= 1'b0;
          if (cur.kind == K_CLEAR) begin
            for (int i = 0; i < NUM_LANES; i++) begin
              count[i]   <= '0;
              running[i] <= '0;
            end
            res.total <= '0;
            state     <= S_DONE;
          end else if (cur.kind == K_QUERY) begin
            q_lane <= '0;
            lo     <= '0;
            hi     <= count[0];
            val    <= '0;
            acc    <= '0;
            state  <= S_Q_ISSUE;
          end else if (do_evt) begin
            running[e_lane] <= cur.amount;
            if (n_evt == '0) begin
              count[e_lane] <= CNT_W'(1);
              state         <= S_TOTAL;
            end else begin
              state <= S_LAST_CHK;
            end
          end else begin
            state <= S_TOTAL;
          end
        end
        S_LAST_CHK: begin
          if (!same_tick && !same_value) begin
            if (n_evt == CNT_W'(MAX_POINTS)) begin
              res.overflow <= 1'b1;
            end else begin
              count[e_lane] <= n_evt + CNT_W'(1);
            end
          end
          state <= S_TOTAL;
        end
        S_TOTAL: begin
          res.total <= sext9(running[0]) + ((lane != '0) ? sext9(running[lane]) : 9'sd0);
          state     <= S_DONE;
        end
        S_Q_ISSUE: begin
          if (lo < hi) begin
            state <= S_Q_CMP;
          end else if (q_lane == '0 && lane != '0) begin
            // global lane finished, now bisect the track lane
            acc    <= acc + sext9(val);
            q_lane <= lane;
            lo     <= '0;
            hi     <= count[lane];
            val    <= '0;
          end else begin
            res.total <= acc + sext9(val);
            state     <= S_DONE;
          end
        end
        S_Q_CMP: begin
          if (cur.tick < rdata.tick) begin
            hi <= mid;
          end else begin
            // entry lo-1 is the one just read, keep its value
            lo  <= mid + CNT_W'(1);
            val <= rdata.value;
          end
          state <= S_Q_ISSUE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status = '{busy: (state != S_IDLE), done: (state == S_DONE), kind: cur.kind};

endmodule

>>> hdl/transpose_change_point_timeline.sv
// sequence: every transaction is dispatched first; plain and first-point events then form the total, a clear
// goes straight to done, and a transaction on a non-empty list checks its last point before the total
// query: bisects the global list, then the track list when the item names a track, with
// one memory read per bisection step
// throughput: one transaction at a time, next accepted in the cycle after the result is registered
// reset clears point counts and running values at once, point memory is not cleared
module transpose_change_point_timeline import tcpt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  ctrl_status_t      status;
  result_t           res;
  logic              start;
  logic              load;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  point_t            wdata;
  point_t            rdata;

  assign item_stall = status.busy;
  assign start      = item_valid && !item_stall;
  assign load       = status.done && (!result_valid || !result_stall);

  tcpt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .take   (load),
    .res    (res),
    .status (status),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rdata  (rdata)
  );

  tcpt_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (DEPTH)
  ) u_points (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> item_stall)
    else $error("sequencer not busy after accepting a transaction");

  a_ovf_kind: assert property (@(posedge clk) disable iff (rst)
    status.done && res.overflow |-> (status.kind == K_GLOBAL || status.kind == K_TRACK))
    else $error("overflow flagged on a non-transpose transaction");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    status.done && status.kind == K_CLEAR |-> res.total == 9'sd0 && !res.overflow)
    else $error("clear returned a non-zero result");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> result_valid && result == $past(res))
    else $error("result register did not take the finished result");
`endif

endmodule
